[rtl/ita_pkg.sv]
// Shared types, opcode codes and character helpers for the integer to ASCII formatter.
// No dependencies.
`default_nettype none
package ita_pkg;

	localparam logic [2:0] OP_SDEC = 3'd0;
	localparam logic [2:0] OP_UDEC = 3'd1;
	localparam logic [2:0] OP_HEXL = 3'd2;
	localparam logic [2:0] OP_HEXU = 3'd3;
	localparam logic [2:0] OP_PTR  = 3'd4;

	typedef enum logic [1:0] {
		PFX_NONE  = 2'd0,
		PFX_MINUS = 2'd1,
		PFX_HEX   = 2'd2,
		PFX_NIL   = 2'd3
	} pfx_kind_t;

	typedef struct packed {
		pfx_kind_t   kind;
		logic        dec;
		logic        upper;
		logic [63:0] mag;
	} ita_job_t;

	typedef struct packed {
		logic     valid;
		ita_job_t job;
	} ita_head_t;

	function automatic logic [2:0] pfx_len(pfx_kind_t kind);
		logic [2:0] len;
		unique case (kind)
			PFX_NONE:  len = 3'd0;
			PFX_MINUS: len = 3'd1;
			PFX_HEX:   len = 3'd2;
			PFX_NIL:   len = 3'd5;
			default:   len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] pfx_char(pfx_kind_t kind, logic [2:0] idx);
		logic [7:0] c;
		c = "-";
		if (kind == PFX_HEX) begin
			c = (idx == 3'd0) ? "0" : "x";
		end else if (kind == PFX_NIL) begin
			unique case (idx)
				3'd0:    c = "(";
				3'd1:    c = "n";
				3'd2:    c = "i";
				3'd3:    c = "l";
				default: c = ")";
			endcase
		end
		return c;
	endfunction

	function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = 8'h30 + {4'd0, d};
		end else if (upper) begin
			c = 8'h37 + {4'd0, d};
		end else begin
			c = 8'h57 + {4'd0, d};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/ita_in_if.sv]
// Input channel: value and format opcode with valid/ready handshake.
// No dependencies.
`default_nettype none
interface ita_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [2:0]  opcode;

	modport source (output valid, output value, output opcode, input ready);
	modport sink   (input valid, input value, input opcode, output ready);
endinterface
`default_nettype wire

[rtl/ita_out_if.sv]
// Output channel: one ASCII character per transaction, with last flag and count.
// No dependencies.
`default_nettype none
interface ita_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;
	logic [4:0] char_count;

	modport source (output valid, output character, output last, output char_count,
		input ready);
	modport sink   (input valid, input character, input last, input char_count,
		output ready);
endinterface
`default_nettype wire

[rtl/integer_to_ascii_formatter.sv]
// Top level of the integer to ASCII formatter: front end, job queue, back end.
// Depends on ita_pkg, ita_in_if, ita_out_if, ita_front, ita_fifo, ita_back.
//
// Usage:
//   item carries value (64 bits) and opcode (0 signed dec, 1 unsigned dec,
//   2 hex lower, 3 hex upper, 4 pointer). Opcodes 5..7 are accepted and
//   produce no characters.
//   text returns one ASCII character per transaction, most significant
//   digit first; last marks the final character and char_count holds the
//   total count there (0 on other characters).
//   Back end steps per item: pop, then for decimal the BCD shift loop
//   over the 32-bit value, a one-nibble-a-cycle skip of leading zeros and
//   emission of the characters, a minus first where present; 32-bit hex
//   and pointers skip and emit likewise, and "(nil)" goes straight to
//   emission. Emission waits while the receiver stalls.
//   The front accepts a new item whenever the job queue (QDEPTH entries)
//   has room, so items queue up while the back end works.
//   Reset clears the queue and the engine; no clearing pass is needed.
//   When the receiver stalls, the output register holds its character
//   and the back end waits; the queue keeps taking items until full.
`default_nettype none
module integer_to_ascii_formatter #(
	parameter int QDEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ita_in_if.sink    item,
	ita_out_if.source text
);
	import ita_pkg::*;

	ita_job_t  job;
	ita_head_t head;
	logic      push;
	logic      pop;
	logic      full;

	ita_front u_front (
		.item   (item),
		.q_full (full),
		.job    (job),
		.push   (push)
	);

	ita_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (job),
		.pop    (pop),
		.head   (head),
		.full   (full)
	);

	ita_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.text   (text)
	);
endmodule
`default_nettype wire

[rtl/ita_front.sv]
// Front end: accepts input transactions, decodes the opcode and builds a job.
// Depends on ita_pkg and ita_in_if.
`default_nettype none
module ita_front (
	ita_in_if.sink          item,
	input  wire logic       q_full,
	output ita_pkg::ita_job_t job,
	output logic            push
);
	import ita_pkg::*;

	logic [31:0] low;
	logic        ok;

	assign low        = item.value[31:0];
	assign item.ready = !q_full;

	always_comb begin
		ok        = 1'b1;
		job.kind  = PFX_NONE;
		job.dec   = 1'b0;
		job.upper = 1'b0;
		job.mag   = {32'd0, low};
		unique case (item.opcode)
			OP_SDEC: begin
				job.dec = 1'b1;
				if (low[31]) begin
					job.kind = PFX_MINUS;
					job.mag  = {32'd0, (~low) + 32'd1};
				end
			end
			OP_UDEC: job.dec = 1'b1;
			OP_HEXL: job.dec = 1'b0;
			OP_HEXU: job.upper = 1'b1;
			OP_PTR: begin
				job.mag  = item.value;
				job.kind = (item.value == 64'd0) ? PFX_NIL : PFX_HEX;
			end
			default: ok = 1'b0;
		endcase
	end

	assign push = item.valid && item.ready && ok;
endmodule
`default_nettype wire

[rtl/ita_fifo.sv]
// Short job queue between front and back ends.
// Depends on ita_pkg.
`default_nettype none
module ita_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ita_pkg::ita_job_t wr_job,
	input  wire logic              pop,
	output ita_pkg::ita_head_t     head,
	output logic                   full
);
	import ita_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ita_job_t        ent_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.job   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule
`default_nettype wire

[rtl/ita_back.sv]
// Back end: binary-to-BCD conversion, leading-zero skip and character emission.
// Depends on ita_pkg and ita_out_if.
`default_nettype none
module ita_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ita_pkg::ita_head_t head,
	output logic              pop,
	ita_out_if.source         text
);
	import ita_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]  state_q;
	pfx_kind_t   kind_q;
	logic        upper_q;
	logic [63:0] dig_q;
	logic [31:0] bin_q;
	logic [39:0] bcd_q;
	logic [4:0]  cyc_q;
	logic [4:0]  rem_q;
	logic [2:0]  pidx_q;
	logic [4:0]  cnt_q;

	logic        ovalid_q;
	logic [7:0]  ochar_q;
	logic        olast_q;
	logic [4:0]  ocnt_q;

	logic [39:0] bcd_adj;
	logic [39:0] bcd_nxt;
	logic [2:0]  plen;
	logic        in_pfx;
	logic [5:0]  left;
	logic        fin;
	logic [7:0]  ch;
	logic        take;

	function automatic logic [39:0] dabble_adj(logic [39:0] b);
		logic [39:0] r;
		r = b;
		for (int i = 0; i < 10; i++) begin
			if (b[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = b[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	assign bcd_adj = dabble_adj(bcd_q);
	assign bcd_nxt = {bcd_adj[38:0], bin_q[31]};

	assign plen   = pfx_len(kind_q);
	assign in_pfx = (pidx_q < plen);
	assign left   = {3'd0, plen - pidx_q} + {1'b0, rem_q};
	assign fin    = (left == 6'd1);
	assign ch     = in_pfx ? pfx_char(kind_q, pidx_q) : digit_char(dig_q[63:60], upper_q);
	assign take   = (state_q == ST_EMIT) && (!ovalid_q || text.ready);
	assign pop    = (state_q == ST_IDLE) && head.valid;

	assign text.valid      = ovalid_q;
	assign text.character  = ochar_q;
	assign text.last       = olast_q;
	assign text.char_count = ocnt_q;

	always_ff @(posedge clk) begin
		if (take) begin
			ochar_q <= ch;
			olast_q <= fin;
			ocnt_q  <= fin ? cnt_q + 5'd1 : 5'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			kind_q   <= PFX_NONE;
			upper_q  <= 1'b0;
			dig_q    <= '0;
			bin_q    <= '0;
			bcd_q    <= '0;
			cyc_q    <= '0;
			rem_q    <= '0;
			pidx_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (take) begin
				ovalid_q <= 1'b1;
			end else if (text.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						kind_q  <= head.job.kind;
						upper_q <= head.job.upper;
						pidx_q  <= '0;
						cnt_q   <= '0;
						if (head.job.dec) begin
							bin_q   <= head.job.mag[31:0];
							bcd_q   <= '0;
							cyc_q   <= '0;
							state_q <= ST_CONV;
						end else if (head.job.kind == PFX_NIL) begin
							rem_q   <= 5'd0;
							state_q <= ST_EMIT;
						end else if (head.job.kind == PFX_HEX) begin
							dig_q   <= head.job.mag;
							rem_q   <= 5'd16;
							state_q <= ST_SKIP;
						end else begin
							dig_q   <= {head.job.mag[31:0], 32'd0};
							rem_q   <= 5'd8;
							state_q <= ST_SKIP;
						end
					end
				end
				ST_CONV: begin
					bcd_q <= bcd_nxt;
					bin_q <= {bin_q[30:0], 1'b0};
					cyc_q <= cyc_q + 5'd1;
					if (cyc_q == 5'd31) begin
						dig_q   <= {bcd_nxt, 24'd0};
						rem_q   <= 5'd10;
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (rem_q > 5'd1 && dig_q[63:60] == 4'd0) begin
						dig_q <= {dig_q[59:0], 4'd0};
						rem_q <= rem_q - 5'd1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (take) begin
						cnt_q <= cnt_q + 5'd1;
						if (in_pfx) begin
							pidx_q <= pidx_q + 3'd1;
						end else begin
							dig_q <= {dig_q[59:0], 4'd0};
							rem_q <= rem_q - 5'd1;
						end
						if (fin) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && olast_q) |-> (ocnt_q >= 5'd1 && ocnt_q <= 5'd18))
		else $error("last character carries a bad count");
	a_skip_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP) |-> (rem_q >= 5'd1 && rem_q <= 5'd16))
		else $error("digit count out of range during skip");
	a_emit_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (left != 6'd0))
		else $error("emitting with nothing left");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q != ST_IDLE))
		else $error("job popped but engine stayed idle");
`endif
endmodule
`default_nettype wire
